// ===== hw/rtl/cfif_pkg.sv =====
// Package for the circular free-interval finder.
// Holds request codes and the sequencer state type; no dependencies.
package cfif_pkg;

  localparam logic [1:0] REQ_START    = 2'd0;
  localparam logic [1:0] REQ_OBSTACLE = 2'd1;
  localparam logic [1:0] REQ_FINISH   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR,
    ST_CUT_BEGIN,
    ST_CUT_RD,
    ST_CUT_EV,
    ST_CUT_END,
    ST_FIN_RD,
    ST_FIN_EV,
    ST_EMIT_RD,
    ST_EMIT_EV,
    ST_EMIT_WAIT
  } cfif_state_e;

endpackage

// ===== hw/rtl/cfif_in_if.sv =====
// Request channel of the circular free-interval finder.
// Valid/ready handshake with the request payload; no dependencies.
interface cfif_in_if #(
  parameter int ANGLE_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            req_type;
  logic [ANGLE_BITS-1:0] angle_a;
  logic [ANGLE_BITS-1:0] angle_b;
  logic                  return_blocked;

  modport source (output valid, req_type, angle_a, angle_b, return_blocked, input ready);
  modport sink   (input valid, req_type, angle_a, angle_b, return_blocked, output ready);
endinterface

// ===== hw/rtl/cfif_out_if.sv =====
// Result channel of the circular free-interval finder.
// Valid/ready handshake with one interval per item; no dependencies.
interface cfif_out_if #(
  parameter int ANGLE_BITS = 16
) ();
  logic                valid;
  logic                ready;
  logic [ANGLE_BITS:0] from_angle;
  logic [ANGLE_BITS:0] to_angle;
  logic                blocked;
  logic                empty_res;
  logic                overflow;
  logic                last;

  modport source (output valid, from_angle, to_angle, blocked, empty_res, overflow, last,
                  input ready);
  modport sink   (input valid, from_angle, to_angle, blocked, empty_res, overflow, last,
                  output ready);
endinterface

// ===== hw/rtl/circular_free_interval_finder_unit.sv =====
// Circular free-interval finder: top level with sequencer and ping-pong boundary memory.
// Depends on cfif_pkg, cfif_in_if and cfif_out_if.
//
// The block keeps a sorted boundary list in a two-bank memory (one write port, two
// registered read ports) and takes one item at a time; in_i.ready is high only while
// the sequencer is idle. A start item writes its 2 or 4 boundaries, one per ST_WR
// visit. An obstacle item passes ST_CUT_BEGIN per arc part (two when the arc wraps;
// a part of zero width passes no other state), then ST_CUT_RD and ST_CUT_EV per stored
// free pair, one ST_WR visit per boundary written into the other bank, and ST_CUT_END.
// A finish item passes ST_FIN_RD and ST_FIN_EV, then ST_EMIT_RD, ST_EMIT_EV and
// ST_EMIT_WAIT per result (only ST_EMIT_WAIT if empty) plus any wait on out_o.ready.
// All cost comes from the single memory write port and one compare unit walking pairs.
module circular_free_interval_finder_unit #(
  parameter int MAX_BOUNDARIES = 32,
  parameter int ANGLE_BITS     = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cfif_in_if.sink    in_i,
  cfif_out_if.source out_o
);
  import cfif_pkg::*;

  localparam int IW = $clog2(MAX_BOUNDARIES);
  localparam int CW = $clog2(MAX_BOUNDARIES + 1);
  localparam int VW = ANGLE_BITS + 1;
  localparam logic [VW-1:0] FULL = {1'b1, {ANGLE_BITS{1'b0}}};
  localparam logic [CW:0]   MAXC = (CW+1)'(MAX_BOUNDARIES);

  cfif_state_e state_q, state_d;
  logic          bank_q, bank_d;
  logic [CW-1:0] count_q, count_d;
  logic          rb_q, rb_d, ovf_q, ovf_d, pend_q, pend_d;
  logic [VW-1:0] lo_q, lo_d, hi_q, hi_d, a_q, a_d;
  logic [CW-1:0] p_q, p_d, m_q, m_d, i_q, i_d, last_q, last_d;
  logic          step2_q, step2_d, merge_q, merge_d, wstart_q, wstart_d, wbank_q, wbank_d;
  logic [VW-1:0] w_q [4];
  logic [VW-1:0] w_d [4];
  logic [2:0]    wn_q, wn_d;
  logic [1:0]    wi_q, wi_d;
  logic [VW-1:0] of_q, of_d, ot_q, ot_d;
  logic          ob_q, ob_d, oe_q, oe_d, ol_q, ol_d;

  logic [VW-1:0] mem [2**(IW+1)];
  logic [VW-1:0] rd0_q, rd1_q;
  logic [IW:0]   ra0, ra1, wa;
  logic          we;

  logic [VW-1:0] in_a, in_b;
  logic [CW:0]   p_next3, i_next1;
  logic [CW-1:0] to_idx, cnt_m1;

  assign in_a    = {1'b0, in_i.angle_a};
  assign in_b    = {1'b0, in_i.angle_b};
  assign p_next3 = {1'b0, p_q} + (CW+1)'(3);
  assign i_next1 = {1'b0, i_q} + (CW+1)'(1);
  assign cnt_m1  = count_q - CW'(1);
  assign to_idx  = (i_q == last_q && merge_q) ? CW'(1) :
                   (i_next1 == {1'b0, count_q}) ? CW'(0) : i_next1[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= w_q[wi_q];
    end
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  always_comb begin
    state_d = state_q;  bank_d = bank_q;   count_d = count_q;
    rb_d = rb_q;        ovf_d = ovf_q;     pend_d = pend_q;
    lo_d = lo_q;        hi_d = hi_q;       a_d = a_q;
    p_d = p_q;          m_d = m_q;         i_d = i_q;       last_d = last_q;
    step2_d = step2_q;  merge_d = merge_q; wstart_d = wstart_q; wbank_d = wbank_q;
    w_d = w_q;          wn_d = wn_q;       wi_d = wi_q;
    of_d = of_q;        ot_d = ot_q;       ob_d = ob_q;     oe_d = oe_q;  ol_d = ol_q;
    ra0 = {bank_q, IW'(0)};
    ra1 = {bank_q, IW'(0)};
    wa  = {wbank_q, m_q[IW-1:0]};
    we  = 1'b0;
    in_i.ready = (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          case (in_i.req_type)
            REQ_START: begin
              rb_d = in_i.return_blocked;
              ovf_d = 1'b0;
              count_d = '0;
              m_d = '0;
              wi_d = '0;
              wbank_d = bank_q;
              wstart_d = 1'b1;
              wn_d = 3'd0;
              if (in_a < in_b) begin
                w_d[0] = in_a; w_d[1] = in_b; wn_d = 3'd2;
              end else if (in_a > in_b && in_b == '0) begin
                w_d[0] = in_a; w_d[1] = FULL; wn_d = 3'd2;
              end else if (in_a > in_b) begin
                w_d[0] = '0; w_d[1] = in_b; w_d[2] = in_a; w_d[3] = FULL; wn_d = 3'd4;
              end
              if (in_a != in_b) state_d = ST_WR;
            end
            REQ_OBSTACLE: begin
              a_d = in_a;
              if (in_a > in_b) begin
                lo_d = '0; hi_d = in_b; pend_d = 1'b1;
              end else begin
                lo_d = in_a; hi_d = in_b; pend_d = 1'b0;
              end
              state_d = ST_CUT_BEGIN;
            end
            REQ_FINISH: state_d = ST_FIN_RD;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_WR: begin
        we = 1'b1;
        m_d = m_q + CW'(1);
        wi_d = wi_q + 2'd1;
        if ({1'b0, wi_q} == wn_q - 3'd1) begin
          if (wstart_q) begin
            count_d = m_q + CW'(1);
            state_d = ST_IDLE;
          end else begin
            p_d = p_q + CW'(2);
            state_d = (p_next3 < {1'b0, count_q}) ? ST_CUT_RD : ST_CUT_END;
          end
        end
      end
      ST_CUT_BEGIN: begin
        p_d = '0;
        m_d = '0;
        if (lo_q < hi_q) begin
          state_d = (count_q > CW'(1)) ? ST_CUT_RD : ST_CUT_END;
        end else if (pend_q) begin
          lo_d = a_q; hi_d = FULL; pend_d = 1'b0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CUT_RD: begin
        ra0 = {bank_q, p_q[IW-1:0]};
        ra1 = {bank_q, p_q[IW-1:0] + IW'(1)};
        state_d = ST_CUT_EV;
      end
      ST_CUT_EV: begin
        wi_d = '0;
        wbank_d = ~bank_q;
        wstart_d = 1'b0;
        if (hi_q <= rd0_q || lo_q >= rd1_q) begin
          w_d[0] = rd0_q; w_d[1] = rd1_q; wn_d = 3'd2;
        end else if (lo_q <= rd0_q && hi_q >= rd1_q) begin
          wn_d = 3'd0;
        end else if (lo_q <= rd0_q) begin
          w_d[0] = hi_q; w_d[1] = rd1_q; wn_d = 3'd2;
        end else if (hi_q >= rd1_q) begin
          w_d[0] = rd0_q; w_d[1] = lo_q; wn_d = 3'd2;
        end else if ({1'b0, count_q} + (CW+1)'(2) > MAXC) begin
          ovf_d = 1'b1;
          w_d[0] = rd0_q; w_d[1] = rd1_q; wn_d = 3'd2;
        end else begin
          w_d[0] = rd0_q; w_d[1] = lo_q; w_d[2] = hi_q; w_d[3] = rd1_q; wn_d = 3'd4;
        end
        if (wn_d == 3'd0) begin
          p_d = p_q + CW'(2);
          state_d = (p_next3 < {1'b0, count_q}) ? ST_CUT_RD : ST_CUT_END;
        end else begin
          state_d = ST_WR;
        end
      end
      ST_CUT_END: begin
        bank_d = ~bank_q;
        count_d = m_q;
        if (pend_q) begin
          lo_d = a_q; hi_d = FULL; pend_d = 1'b0;
          state_d = ST_CUT_BEGIN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FIN_RD: begin
        ra0 = {bank_q, IW'(0)};
        ra1 = {bank_q, cnt_m1[IW-1:0]};
        state_d = ST_FIN_EV;
      end
      ST_FIN_EV: begin
        step2_d = ~rb_q;
        if (count_q == '0) begin
          of_d = '0; ot_d = '0; ob_d = 1'b0; oe_d = 1'b1; ol_d = 1'b1;
          state_d = ST_EMIT_WAIT;
        end else begin
          merge_d = (rd0_q == '0) && (rd1_q == FULL) && (count_q > CW'(2));
          if (merge_d) begin
            i_d = rb_q ? CW'(1) : CW'(2);
            last_d = count_q - CW'(2);
          end else begin
            i_d = '0;
            if (!rb_q) last_d = count_q - CW'(2);
            else if (rd0_q == '0 && rd1_q == FULL) last_d = '0;
            else last_d = cnt_m1;
          end
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        ra0 = {bank_q, i_q[IW-1:0]};
        ra1 = {bank_q, to_idx[IW-1:0]};
        state_d = ST_EMIT_EV;
      end
      ST_EMIT_EV: begin
        of_d = rd0_q; ot_d = rd1_q; ob_d = i_q[0]; oe_d = 1'b0;
        ol_d = (i_q == last_q);
        state_d = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (out_o.ready) begin
          if (ol_q) begin
            state_d = ST_IDLE;
          end else begin
            i_d = i_q + (step2_q ? CW'(2) : CW'(1));
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_o.valid      = (state_q == ST_EMIT_WAIT);
  assign out_o.from_angle = of_q;
  assign out_o.to_angle   = ot_q;
  assign out_o.blocked    = ob_q;
  assign out_o.empty_res  = oe_q;
  assign out_o.overflow   = ovf_q;
  assign out_o.last       = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      bank_q  <= 1'b0;
      count_q <= '0;
      rb_q    <= 1'b0;
      ovf_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      count_q <= count_d;
      rb_q    <= rb_d;
      ovf_q   <= ovf_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;  hi_q <= hi_d;  a_q <= a_d;
    p_q <= p_d;    m_q <= m_d;    i_q <= i_d;   last_q <= last_d;
    step2_q <= step2_d;  merge_q <= merge_d;  wstart_q <= wstart_d;  wbank_q <= wbank_d;
    w_q <= w_d;    wn_q <= wn_d;  wi_q <= wi_d;
    of_q <= of_d;  ot_q <= ot_d;  ob_q <= ob_d;  oe_q <= oe_d;  ol_q <= ol_d;
  end

  a_count_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q[0] == 1'b0) else $error("odd boundary count");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.empty_res |-> out_o.last) else $error("empty item not last");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready) else $error("request taken while result pending");

  a_wr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WR |-> ({1'b0, wi_q} < wn_q) && ({1'b0, m_q} < MAXC))
    else $error("write list overrun");

endmodule

// ===== verif/cfif_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench types for the request and result items of the interval finder.
// Depends on nothing; the RTL interfaces cfif_in_if and cfif_out_if are used directly.
package cfif_tb_pkg;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [15:0] a;
    logic [15:0] b;
    logic        rb;
  } req_t;

  typedef struct packed {
    logic [16:0] from_a;
    logic [16:0] to_a;
    logic        blk;
    logic        empty;
    logic        ovf;
    logic        last;
  } ival_t;

endpackage

// ===== verif/circular_free_interval_finder_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of circular_free_interval_finder_unit: directed table, then random
// search arcs, obstacles and finish requests checked against an interval predictor.
// Depends on cfif_pkg, cfif_tb_pkg, cfif_in_if, cfif_out_if and the unit itself.
module circular_free_interval_finder_unit_test;
  import cfif_pkg::*;
  import cfif_tb_pkg::*;

  localparam int NB = 32;
  localparam int AB = 16;
  localparam logic [16:0] FULL = 17'h10000;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk_i = 0;
  logic rst_ni = 0;
  cfif_in_if #(AB) in_ch ();
  cfif_out_if #(AB) out_ch ();

  circular_free_interval_finder_unit #(.MAX_BOUNDARIES(NB), .ANGLE_BITS(AB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source));

  logic [16:0] bnd[NB];
  int          bnd_n;
  logic        rep_blk;
  logic        ovf_flag;
  ival_t       expected_ivals[$];
  int          errors = 0;
  int          n_results = 0;
  int          n_reqs = 0;
  int          cycles = 0;
  bit          hold_off = 0;
  bit          stim_done = 0;

  initial forever #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void cut_arc(logic [16:0] lo, logic [16:0] hi);
    logic [16:0] t[NB+4];
    int m;
    logic [16:0] s, e;
    m = 0;
    if (lo >= hi) return;
    for (int p = 0; p + 1 < bnd_n; p += 2) begin
      s = bnd[p];
      e = bnd[p+1];
      if (hi <= s || lo >= e) begin
        t[m] = s; t[m+1] = e; m += 2;
      end else if (lo <= s && hi >= e) begin
      end else if (lo <= s) begin
        t[m] = hi; t[m+1] = e; m += 2;
      end else if (hi >= e) begin
        t[m] = s; t[m+1] = lo; m += 2;
      end else if (bnd_n + 2 > NB) begin
        ovf_flag = 1;
        t[m] = s; t[m+1] = e; m += 2;
      end else begin
        t[m] = s; t[m+1] = lo; t[m+2] = hi; t[m+3] = e; m += 4;
      end
    end
    if (m > NB) m = NB;
    for (int i = 0; i < m; i++) bnd[i] = t[i];
    bnd_n = m;
  endfunction

  function automatic void predict_intervals(req_t r);
    logic [16:0] fr[NB], tt[NB];
    logic bk[NB];
    int k, j;
    bit changed;
    ival_t v;
    k = 0;
    case (r.req)
      REQ_START: begin
        rep_blk = r.rb;
        ovf_flag = 0;
        bnd_n = 0;
        if (r.a < r.b) begin
          bnd[0] = {1'b0, r.a}; bnd[1] = {1'b0, r.b}; bnd_n = 2;
        end else if (r.a > r.b && r.b == 0) begin
          bnd[0] = {1'b0, r.a}; bnd[1] = FULL; bnd_n = 2;
        end else if (r.a > r.b) begin
          bnd[0] = '0; bnd[1] = {1'b0, r.b}; bnd[2] = {1'b0, r.a}; bnd[3] = FULL; bnd_n = 4;
        end
      end
      REQ_OBSTACLE: begin
        if (r.a > r.b) begin
          cut_arc('0, {1'b0, r.b});
          cut_arc({1'b0, r.a}, FULL);
        end else begin
          cut_arc({1'b0, r.a}, {1'b0, r.b});
        end
      end
      REQ_FINISH: begin
        for (int i = 0; i < bnd_n; i++) begin
          if (!(i[0] && !rep_blk) && !(bnd[i] == FULL && bnd[(i+1) % bnd_n] == 0)
              && k < NB) begin
            fr[k] = bnd[i]; tt[k] = bnd[(i+1) % bnd_n]; bk[k] = i[0]; k++;
          end
        end
        changed = 1;
        while (changed && k > 1) begin
          changed = 0;
          for (int i = 0; i < k && !changed; i++) begin
            j = (i + 1 < k) ? i + 1 : 0;
            if ((tt[i] == fr[j] || (tt[i] == FULL && fr[j] == 0)) && bk[i] == bk[j]) begin
              tt[i] = tt[j];
              for (int q = j; q + 1 < k; q++) begin
                fr[q] = fr[q+1]; tt[q] = tt[q+1]; bk[q] = bk[q+1];
              end
              k--;
              changed = 1;
            end
          end
        end
        if (k == 0) begin
          v = '{'0, '0, 1'b0, 1'b1, ovf_flag, 1'b1};
          expected_ivals = {expected_ivals, v};
        end
        for (int i = 0; i < k; i++) begin
          v = '{fr[i], tt[i], bk[i], 1'b0, ovf_flag, i == k - 1};
          expected_ivals = {expected_ivals, v};
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(req_t r);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.req_type <= r.req;
    in_ch.angle_a <= r.a;
    in_ch.angle_b <= r.b;
    in_ch.return_blocked <= r.rb;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_intervals(r);
    n_reqs++;
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'(($urandom_range(0, 15)) << 12);
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      n_results++;
      if (expected_ivals.size() == 0) begin
        $error("unexpected interval from=%0d to=%0d", out_ch.from_angle, out_ch.to_angle);
        errors++;
      end else begin
        ival_t x;
        x = expected_ivals.pop_front();
        if (out_ch.from_angle !== x.from_a) begin
          $error("from_angle exp %0d got %0d", x.from_a, out_ch.from_angle); errors++;
        end
        if (out_ch.to_angle !== x.to_a) begin
          $error("to_angle exp %0d got %0d", x.to_a, out_ch.to_angle); errors++;
        end
        if (out_ch.blocked !== x.blk) begin
          $error("blocked exp %0d got %0d", x.blk, out_ch.blocked); errors++;
        end
        if (out_ch.empty_res !== x.empty) begin
          $error("empty_res exp %0d got %0d", x.empty, out_ch.empty_res); errors++;
        end
        if (out_ch.overflow !== x.ovf) begin
          $error("overflow exp %0d got %0d", x.ovf, out_ch.overflow); errors++;
        end
        if (out_ch.last !== x.last) begin
          $error("last exp %0d got %0d", x.last, out_ch.last); errors++;
        end
      end
    end
  end

  initial begin
    int r;
    out_ch.ready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ch.ready <= 0;
      end else begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          out_ch.ready <= 0;
          repeat ($urandom_range(10, 40)) @(posedge clk_i);
          out_ch.ready <= 1;
        end else begin
          out_ch.ready <= (r > 4) || stim_done;
        end
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    wait (n_reqs >= 150);
    @(posedge clk_i);
    hold_off <= 1;
    repeat (400) @(posedge clk_i);
    hold_off <= 0;
  end

  initial begin
    req_t dir_tbl[$];
    ival_t known_tbl[$];
    req_t rq;
    int nobs;
    in_ch.valid = 0;
    in_ch.req_type = REQ_START;
    in_ch.angle_a = 0;
    in_ch.angle_b = 0;
    in_ch.return_blocked = 0;
    bnd_n = 0;
    rep_blk = 0;
    ovf_flag = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    dir_tbl = '{
      '{REQ_FINISH, 16'd0, 16'd0, 1'b0},
      '{REQ_OBSTACLE, 16'd10, 16'd20, 1'b0},
      '{REQ_START, 16'd100, 16'd100, 1'b1},
      '{REQ_FINISH, 16'd0, 16'd0, 1'b0},
      '{REQ_START, 16'd0, 16'hFFFF, 1'b0},
      '{REQ_FINISH, 16'd0, 16'd0, 1'b0},
      '{REQ_START, 16'hFFFF, 16'd0, 1'b1},
      '{REQ_FINISH, 16'd0, 16'd0, 1'b0},
      '{REQ_START, 16'hC000, 16'h4000, 1'b1},
      '{REQ_OBSTACLE, 16'h1000, 16'h1000, 1'b0},
      '{REQ_OBSTACLE, 16'h1000, 16'h2000, 1'b0},
      '{REQ_OBSTACLE, 16'h0000, 16'h0800, 1'b0},
      '{REQ_OBSTACLE, 16'h3000, 16'h5000, 1'b0},
      '{REQ_OBSTACLE, 16'hF000, 16'h0100, 1'b0},
      '{REQ_OBSTACLE, 16'h8000, 16'h9000, 1'b0},
      '{REQ_UNKNOWN, 16'hFFFF, 16'hFFFF, 1'b1},
      '{REQ_FINISH, 16'hFFFF, 16'hFFFF, 1'b1},
      '{REQ_START, 16'h2000, 16'h6000, 1'b0},
      '{REQ_OBSTACLE, 16'h0000, 16'hFFFF, 1'b0},
      '{REQ_FINISH, 16'd0, 16'd0, 1'b0}
    };
    known_tbl = '{'{17'd0, 17'd0, 1'b0, 1'b1, 1'b0, 1'b1}};
    foreach (dir_tbl[i]) begin
      send_req(dir_tbl[i]);
      if (i == 0 && expected_ivals.size() == 1 && expected_ivals[0] !== known_tbl[0]) begin
        $error("predictor empty result exp %p got %p", known_tbl[0], expected_ivals[0]);
        errors++;
      end
    end

    for (int s = 0; s < 55; s++) begin
      rq = '{REQ_START, rand_angle(), rand_angle(), 1'($urandom)};
      if ($urandom_range(0, 15) == 0) rq.b = rq.a;
      send_req(rq);
      nobs = (s % 9 == 0) ? $urandom_range(16, 24) : $urandom_range(0, 6);
      for (int o = 0; o < nobs; o++) begin
        rq = '{REQ_OBSTACLE, rand_angle(), rand_angle(), 1'($urandom)};
        if (s % 9 == 0) rq.b = rq.a + 16'($urandom_range(1, 600));
        send_req(rq);
      end
      if ($urandom_range(0, 9) == 0) begin
        send_req('{REQ_UNKNOWN, rand_angle(), rand_angle(), 1'($urandom)});
      end
      send_req('{REQ_FINISH, rand_angle(), rand_angle(), 1'($urandom)});
    end
    in_ch.valid <= 0;

    stim_done = 1;
    while (expected_ivals.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d requests (starts, obstacles, finishes, unknown codes),", n_reqs);
    $display("checked %0d interval results incl. overflow and output stall.", n_results);
    if (errors == 0 && expected_ivals.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
